FILE: sv/miq_pkg.sv
package miq_pkg;

    localparam int OPCODE_W     = 2;
    localparam int ID_W         = 16;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 11;
    localparam int CAPACITY_DEF = 1024;
    localparam int ID_BITS_DEF  = 16;

    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_MID  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP       = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_PUSHED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_POPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ID_W-1:0]     item_id;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     popped_id;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

endpackage

FILE: sv/miq_half_mem.sv
module miq_half_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/miq_ctrl.sv
module miq_ctrl
    import miq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    parameter int IDX_W    = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmd_t               cmd,
    output logic               busy,
    output logic               done,
    output result_t            result,
    output logic               rd_en,
    output logic [IDX_W-1:0]   front_raddr,
    input  logic [ID_BITS-1:0] front_rdata,
    output logic               front_we,
    output logic [IDX_W-1:0]   front_waddr,
    output logic [ID_BITS-1:0] front_wdata,
    output logic [IDX_W-1:0]   back_raddr,
    input  logic [ID_BITS-1:0] back_rdata,
    output logic               back_we,
    output logic [IDX_W-1:0]   back_waddr,
    output logic [ID_BITS-1:0] back_wdata
);

    localparam int HALF  = (CAPACITY + 1) / 2;
    localparam int CNT_W = $clog2(HALF + 1);
    localparam int TOT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    fh_reg, fh_next, bh_reg, bh_next;
    logic [CNT_W-1:0]    fc_reg, fc_next, bc_reg, bc_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic                accept;
    logic [ID_BITS+ID_W-1:0] id_ext;
    logic [ID_BITS+ID_W-1:0] pop_ext;
    logic [TOT_W-1:0]    total, total_next;
    logic [TOT_W+OCC_W-1:0] occ_ext;
    logic                is_pop, is_mid, full, equal, empty;
    logic [IDX_W:0]      front_sum, back_sum;
    logic [IDX_W-1:0]    front_tail, back_tail, fh_inc, bh_inc, bh_dec;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign result = res_reg;

    assign rd_en       = accept;
    assign front_raddr = fh_reg;
    assign back_raddr  = bh_reg;

    assign id_ext  = (ID_BITS + ID_W)'(cmd.item_id);
    assign pop_ext = (ID_BITS + ID_W)'(front_rdata);

    // circular index arithmetic, half depth need not be a power of two
    assign front_sum  = {1'b0, fh_reg} + (IDX_W + 1)'(fc_reg);
    assign back_sum   = {1'b0, bh_reg} + (IDX_W + 1)'(bc_reg);
    assign front_tail = (front_sum >= (IDX_W + 1)'(HALF)) ?
                        IDX_W'(front_sum - (IDX_W + 1)'(HALF)) : IDX_W'(front_sum);
    assign back_tail  = (back_sum >= (IDX_W + 1)'(HALF)) ?
                        IDX_W'(back_sum - (IDX_W + 1)'(HALF)) : IDX_W'(back_sum);
    assign fh_inc = (fh_reg == IDX_W'(HALF - 1)) ? '0 : fh_reg + IDX_W'(1);
    assign bh_inc = (bh_reg == IDX_W'(HALF - 1)) ? '0 : bh_reg + IDX_W'(1);
    assign bh_dec = (bh_reg == '0) ? IDX_W'(HALF - 1) : bh_reg - IDX_W'(1);

    assign is_pop = op_reg[1];
    assign is_mid = !op_reg[1] && op_reg[0];
    assign total  = TOT_W'(fc_reg) + TOT_W'(bc_reg);
    assign full   = (total >= TOT_W'(CAPACITY));
    assign equal  = (fc_reg == bc_reg);
    assign empty  = (fc_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        fh_next     = fh_reg;
        bh_next     = bh_reg;
        fc_next     = fc_reg;
        bc_next     = bc_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        total_next  = '0;
        occ_ext     = '0;
        front_we    = 1'b0;
        front_waddr = front_tail;
        front_wdata = id_reg;
        back_we     = 1'b0;
        back_waddr  = back_tail;
        back_wdata  = id_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                res_next.popped_id = '0;
                if (is_pop)
                begin
                    if (empty)
                    begin
                        res_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        res_next.status    = STAT_POPPED;
                        res_next.popped_id = pop_ext[ID_W-1:0];
                        fh_next = fh_inc;
                        if (equal)
                        begin
                            // back half front moves over to refill the front half
                            front_we    = 1'b1;
                            front_wdata = back_rdata;
                            bh_next     = bh_inc;
                            bc_next     = bc_reg - CNT_W'(1);
                        end
                        else
                        begin
                            fc_next = fc_reg - CNT_W'(1);
                        end
                    end
                end
                else if (full)
                begin
                    res_next.status = STAT_FULL;
                end
                else if (!is_mid)
                begin
                    res_next.status = STAT_PUSHED;
                    back_we = 1'b1;
                    if (equal)
                    begin
                        front_we    = 1'b1;
                        front_wdata = (bc_reg == '0) ? id_reg : back_rdata;
                        fc_next     = fc_reg + CNT_W'(1);
                        bh_next     = bh_inc;
                    end
                    else
                    begin
                        bc_next = bc_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    res_next.status = STAT_PUSHED;
                    if (equal)
                    begin
                        front_we = 1'b1;
                        fc_next  = fc_reg + CNT_W'(1);
                    end
                    else
                    begin
                        back_we    = 1'b1;
                        back_waddr = bh_dec;
                        bh_next    = bh_dec;
                        bc_next    = bc_reg + CNT_W'(1);
                    end
                end
                total_next = TOT_W'(fc_next) + TOT_W'(bc_next);
                occ_ext    = (TOT_W + OCC_W)'(total_next);
                res_next.occupancy = occ_ext[OCC_W-1:0];
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fh_reg    <= '0;
            bh_reg    <= '0;
            fc_reg    <= '0;
            bc_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fh_reg    <= fh_next;
            bh_reg    <= bh_next;
            fc_reg    <= fc_next;
            bc_reg    <= bc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            op_reg <= cmd.opcode;
            id_reg <= id_ext[ID_BITS-1:0];
        end
    end

endmodule

FILE: sv/middle_insert_queue_core.sv
// Queue of item ids with push at the back, push at the middle and pop from the front.
// A command is taken when start is high and busy is low; the head entries of the two
// half stores (synchronous memories, one read port each) are read as it is taken, and
// entries are written back and the pointers updated while busy is high, so a new
// command waits until busy is low. The result beat shows on result with done high
// for exactly one cycle, the cycle after busy falls, and must be captured then: the
// receiver cannot stall it. No clearing pass runs after reset; the block is ready
// in the first cycle.
module middle_insert_queue_core
    import miq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int HALF  = (CAPACITY + 1) / 2;
    localparam int IDX_W = (HALF > 1) ? $clog2(HALF) : 1;

    logic               rd_en;
    logic [IDX_W-1:0]   front_raddr, front_waddr, back_raddr, back_waddr;
    logic [ID_BITS-1:0] front_rdata, front_wdata, back_rdata, back_wdata;
    logic               front_we, back_we;

    miq_ctrl #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .rd_en       (rd_en),
        .front_raddr (front_raddr),
        .front_rdata (front_rdata),
        .front_we    (front_we),
        .front_waddr (front_waddr),
        .front_wdata (front_wdata),
        .back_raddr  (back_raddr),
        .back_rdata  (back_rdata),
        .back_we     (back_we),
        .back_waddr  (back_waddr),
        .back_wdata  (back_wdata)
    );

    miq_half_mem #(
        .DEPTH  (HALF),
        .ADDR_W (IDX_W),
        .DATA_W (ID_BITS)
    ) u_front_mem (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .re    (rd_en),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    miq_half_mem #(
        .DEPTH  (HALF),
        .ADDR_W (IDX_W),
        .DATA_W (ID_BITS)
    ) u_back_mem (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .re    (rd_en),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

endmodule

FILE: sv/miq_checker.sv
module miq_checker
    import miq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // an accepted command raises busy; once busy drops, its result beat shows
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("busy cycle not followed by a result beat");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a command in flight");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == STAT_EMPTY |-> result.occupancy == '0)
        else $error("pop on empty with nonzero occupancy");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STAT_POPPED |-> result.popped_id == '0)
        else $error("popped id nonzero on a non-pop beat");

endmodule

bind middle_insert_queue_core miq_checker u_miq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
